FILE: rtl/kgct_pkg.sv
`default_nettype none
package kgct_pkg;

   localparam int REQ_DATA_W = 176;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 112;
   localparam int RSP_USER_W = 2;
   localparam int CSR_DATA_W = 31;
   localparam int CSR_INDEX_W = 1;

   localparam int ROT_FRAC = 16;
   localparam logic signed [15:0] QUAT_ONE = 16'sd16384;
   localparam logic [30:0] TRANS_THR_RST = 31'd32768;
   localparam logic [14:0] COS_HALF_RST = 15'd16244;

   localparam logic [4:0] DIV_LAST = 5'd16;
   localparam logic [3:0] ENT_LAST = 4'd8;

   typedef enum logic [0:0] {
      CSR_TRANS_THR = 1'b0,
      CSR_COS_HALF  = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      MODE_POSE  = 1'b0,
      MODE_POINT = 1'b1
   } mode_type;

   typedef enum logic [3:0] {
      MS_NONE, MS_TMAG, MS_THR, MS_DOT, MS_LSQ, MS_KSQ, MS_PAIR,
      MS_DD, MS_CC, MS_NN, MS_HIC, MS_LOC
   } mul_sel_type;

   typedef enum logic [3:0] {
      AO_NONE, AO_TSUM, AO_TTHR, AO_DOT, AO_LSQ, AO_KSQ, AO_PAIR,
      AO_DD, AO_CC, AO_NN, AO_HIC, AO_LOC
   } acc_op_type;

   typedef struct packed {
      mul_sel_type msel;
      acc_op_type  aop;
      logic [2:0]  idx;
   } uop_type;

   localparam uop_type UOP_IDLE = '{MS_NONE, AO_NONE, 3'd0};

   // frame setup program for the shared multiplier
   localparam int UPROG_LEN = 28;
   localparam uop_type UPROG [UPROG_LEN] = '{
      '{MS_TMAG, AO_TSUM, 3'd0},
      '{MS_TMAG, AO_TSUM, 3'd1},
      '{MS_TMAG, AO_TSUM, 3'd2},
      '{MS_THR,  AO_TTHR, 3'd0},
      '{MS_DOT,  AO_DOT,  3'd0},
      '{MS_DOT,  AO_DOT,  3'd1},
      '{MS_DOT,  AO_DOT,  3'd2},
      '{MS_DOT,  AO_DOT,  3'd3},
      '{MS_LSQ,  AO_LSQ,  3'd0},
      '{MS_LSQ,  AO_LSQ,  3'd1},
      '{MS_LSQ,  AO_LSQ,  3'd2},
      '{MS_LSQ,  AO_LSQ,  3'd3},
      '{MS_KSQ,  AO_KSQ,  3'd0},
      '{MS_KSQ,  AO_KSQ,  3'd1},
      '{MS_KSQ,  AO_KSQ,  3'd2},
      '{MS_KSQ,  AO_KSQ,  3'd3},
      '{MS_DD,   AO_DD,   3'd0},
      '{MS_CC,   AO_CC,   3'd0},
      '{MS_PAIR, AO_PAIR, 3'd0},
      '{MS_PAIR, AO_PAIR, 3'd1},
      '{MS_PAIR, AO_PAIR, 3'd2},
      '{MS_PAIR, AO_PAIR, 3'd3},
      '{MS_PAIR, AO_PAIR, 3'd4},
      '{MS_PAIR, AO_PAIR, 3'd5},
      '{MS_NN,   AO_NN,   3'd0},
      '{MS_NONE, AO_NONE, 3'd0},
      '{MS_HIC,  AO_HIC,  3'd0},
      '{MS_LOC,  AO_LOC,  3'd0}
   };

   typedef enum logic [1:0] {
      XA_NONE, XA_SET, XA_ADD
   } xacc_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LATCH, ST_MUL, ST_DLOAD, ST_DSTEP, ST_DSTORE, ST_DECIDE,
      ST_POINT, ST_X0, ST_X1, ST_X2, ST_X3, ST_XFIN, ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic       capture;
      logic       pose_load;
      logic       latch;
      uop_type    uop;
      logic       div_load;
      logic       div_step;
      logic       div_store;
      logic [3:0] ent;
      logic [1:0] xcol;
      xacc_type   xacc;
      logic       xfin;
      logic       out_load;
      logic       out_point;
      logic       out_end;
      logic       out_kf;
      logic       kf_load;
   } dp_cmd_type;

   typedef struct packed {
      mode_type in_mode;
      logic     pt_ok;
      logic     pt_last;
      logic     trans_pass;
      logic     rot_pass;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: rtl/kgct_ctrl.sv
`default_nettype none
module kgct_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire kgct_pkg::dp_status_type status,
   output kgct_pkg::dp_cmd_type         cmd
);
   import kgct_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [4:0] pc_ff, pc_in;
   logic [4:0] bit_ff, bit_in;
   logic [3:0] ent_ff, ent_in;
   logic frame_open_ff, frame_open_in;
   logic accepted_ff, accepted_in;
   logic had_point_ff, had_point_in;
   logic latest_valid_ff, latest_valid_in;
   logic kf_valid_ff, kf_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic can_load;
   logic pt_use;
   logic kf_take;

   assign rsp_tvalid = rsp_valid_ff;
   assign can_load = !rsp_valid_ff || rsp_tready;
   assign pt_use = accepted_ff && status.pt_ok;
   assign kf_take = status.pt_last && (had_point_ff || pt_use);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pc_ff           <= '0;
         bit_ff          <= '0;
         ent_ff          <= '0;
         frame_open_ff   <= 1'b0;
         accepted_ff     <= 1'b0;
         had_point_ff    <= 1'b0;
         latest_valid_ff <= 1'b0;
         kf_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pc_ff           <= pc_in;
         bit_ff          <= bit_in;
         ent_ff          <= ent_in;
         frame_open_ff   <= frame_open_in;
         accepted_ff     <= accepted_in;
         had_point_ff    <= had_point_in;
         latest_valid_ff <= latest_valid_in;
         kf_valid_ff     <= kf_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      pc_in           = pc_ff;
      bit_in          = bit_ff;
      ent_in          = ent_ff;
      frame_open_in   = frame_open_ff;
      accepted_in     = accepted_ff;
      had_point_in    = had_point_ff;
      latest_valid_in = latest_valid_ff;
      kf_valid_in     = kf_valid_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      req_tready      = 1'b0;
      cmd             = '0;
      cmd.uop         = UOP_IDLE;
      cmd.xacc        = XA_NONE;
      cmd.ent         = ent_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               if (status.in_mode == MODE_POSE) begin
                  cmd.pose_load   = 1'b1;
                  latest_valid_in = 1'b1;
               end else if (frame_open_ff) begin
                  state_in = ST_POINT;
               end else begin
                  frame_open_in = 1'b1;
                  had_point_in  = 1'b0;
                  state_in      = ST_LATCH;
               end
            end
         end
         ST_LATCH: begin
            cmd.latch = 1'b1;
            pc_in     = '0;
            ent_in    = '0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.uop = UPROG[pc_ff];
            if (pc_ff == 5'(UPROG_LEN - 1)) begin
               state_in = ST_DLOAD;
            end else begin
               pc_in = pc_ff + 5'd1;
            end
         end
         ST_DLOAD: begin
            cmd.div_load = 1'b1;
            bit_in       = '0;
            state_in     = ST_DSTEP;
         end
         ST_DSTEP: begin
            cmd.div_step = 1'b1;
            if (bit_ff == DIV_LAST) begin
               state_in = ST_DSTORE;
            end else begin
               bit_in = bit_ff + 5'd1;
            end
         end
         ST_DSTORE: begin
            cmd.div_store = 1'b1;
            if (ent_ff == ENT_LAST) begin
               state_in = ST_DECIDE;
            end else begin
               ent_in   = ent_ff + 4'd1;
               state_in = ST_DLOAD;
            end
         end
         ST_DECIDE: begin
            accepted_in = latest_valid_ff &&
               (!kf_valid_ff || status.trans_pass || status.rot_pass);
            state_in = ST_POINT;
         end
         ST_POINT: begin
            if (pt_use) begin
               state_in = ST_X0;
            end else if (status.pt_last && accepted_ff) begin
               state_in = ST_EMIT;
            end else begin
               if (status.pt_last) begin
                  frame_open_in = 1'b0;
                  accepted_in   = 1'b0;
                  had_point_in  = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_X0: begin
            cmd.xcol = 2'd0;
            state_in = ST_X1;
         end
         ST_X1: begin
            cmd.xcol = 2'd1;
            cmd.xacc = XA_SET;
            state_in = ST_X2;
         end
         ST_X2: begin
            cmd.xcol = 2'd2;
            cmd.xacc = XA_ADD;
            state_in = ST_X3;
         end
         ST_X3: begin
            cmd.xacc = XA_ADD;
            state_in = ST_XFIN;
         end
         ST_XFIN: begin
            cmd.xfin = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (can_load) begin
               cmd.out_load  = 1'b1;
               cmd.out_point = pt_use;
               cmd.out_end   = status.pt_last;
               cmd.out_kf    = kf_take;
               cmd.kf_load   = kf_take;
               rsp_valid_in  = 1'b1;
               if (pt_use) begin
                  had_point_in = 1'b1;
               end
               if (status.pt_last) begin
                  frame_open_in = 1'b0;
                  accepted_in   = 1'b0;
                  had_point_in  = 1'b0;
                  if (kf_take) begin
                     kf_valid_in = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/kgct_dpath.sv
`default_nettype none
module kgct_dpath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [kgct_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [kgct_pkg::REQ_USER_W-1:0]   req_tuser,
   input  wire logic                              req_tlast,
   output logic [kgct_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [kgct_pkg::RSP_USER_W-1:0]        rsp_tuser,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_we,
   input  wire logic [kgct_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [kgct_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire kgct_pkg::dp_cmd_type              cmd,
   output kgct_pkg::dp_status_type                status
);
   import kgct_pkg::*;

   logic [30:0] thr_ff;
   logic [14:0] cos_ff;

   logic signed [31:0] lpos_ff [3];
   logic signed [15:0] lq_ff [4];
   logic signed [31:0] kpos_ff [3];
   logic signed [15:0] kq_ff [4];

   logic signed [31:0] in_coord [3];
   logic signed [15:0] in_quat [4];

   logic signed [31:0] pt_ff [3];
   logic [15:0] pt_int_ff;
   logic pt_ok_ff;
   logic pt_last_ff;

   logic signed [31:0] fp_pos_ff [3];
   logic signed [15:0] fp_q_ff [4];
   logic signed [15:0] qn_ff [4];
   logic signed [15:0] kn_ff [4];
   logic [32:0] mag_ff [3];

   logic lq_zero, kq_zero;

   logic signed [33:0] ma, mb;
   logic signed [67:0] prod_ff;
   uop_type pend_ff;

   logic [63:0] tsum_ff;
   logic [61:0] tthr_ff;
   logic signed [34:0] dot_ff;
   logic signed [34:0] dot_abs;
   logic [30:0] sq_ff [4];
   logic signed [31:0] pr_ff [6];
   logic [32:0] na_ff, nb_ff;
   logic [64:0] dd_ff;
   logic [29:0] csq_ff;
   logic [31:0] phi_ff;
   logic [32:0] plo_ff;
   logic [95:0] rhs_ff;

   logic signed [34:0] sx, sy, sz, sw;
   logic signed [34:0] pxy, pwz, pxz, pwy, pyz, pwx;
   logic signed [34:0] num;
   logic signed [34:0] num_abs;
   logic [49:0] rem_ff, dsr_ff;
   logic [16:0] qt_ff;
   logic neg_ff;
   logic signed [17:0] qe;
   logic signed [17:0] rot_ff [9];

   logic signed [17:0] xrot [3];
   logic signed [31:0] xpt;
   logic signed [49:0] xprod_ff [3];
   logic signed [51:0] xacc_ff [3];
   logic signed [36:0] xsum [3];
   logic signed [31:0] xres_ff [3];

   logic signed [31:0] out_map_ff [3];
   logic [15:0] out_int_ff;
   logic out_present_ff, out_end_ff, out_kf_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_coord[i] = $signed(req_tdata[32*i +: 32]);
      end
      for (int i = 0; i < 4; i++) begin
         in_quat[i] = $signed(req_tdata[96 + 16*i +: 16]);
      end
   end

   assign lq_zero = (lq_ff[0] == '0) && (lq_ff[1] == '0) && (lq_ff[2] == '0) &&
                    (lq_ff[3] == '0);
   assign kq_zero = (kq_ff[0] == '0) && (kq_ff[1] == '0) && (kq_ff[2] == '0) &&
                    (kq_ff[3] == '0);

   // configuration, latest pose and keyframe pose
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= TRANS_THR_RST;
         cos_ff <= COS_HALF_RST;
         for (int i = 0; i < 3; i++) begin
            lpos_ff[i] <= '0;
            kpos_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            lq_ff[i] <= '0;
            kq_ff[i] <= '0;
         end
         lq_ff[3] <= QUAT_ONE;
         kq_ff[3] <= QUAT_ONE;
         pend_ff  <= UOP_IDLE;
      end else begin
         pend_ff <= cmd.uop;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_TRANS_THR: thr_ff <= csr_wdata;
               CSR_COS_HALF:  cos_ff <= csr_wdata[14:0];
               default: ;
            endcase
         end
         if (cmd.pose_load) begin
            for (int i = 0; i < 3; i++) lpos_ff[i] <= in_coord[i];
            for (int i = 0; i < 4; i++) lq_ff[i] <= in_quat[i];
         end
         if (cmd.kf_load) begin
            for (int i = 0; i < 3; i++) kpos_ff[i] <= fp_pos_ff[i];
            for (int i = 0; i < 4; i++) kq_ff[i] <= fp_q_ff[i];
         end
      end
   end

   // shared multiplier operands
   always_comb begin
      ma = '0;
      mb = '0;
      dot_abs = (dot_ff < 0) ? -dot_ff : dot_ff;
      unique case (cmd.uop.msel)
         MS_NONE: ;
         MS_TMAG: begin
            ma = $signed({3'b0, mag_ff[cmd.uop.idx[1:0]][30:0]});
            mb = ma;
         end
         MS_THR: begin
            ma = $signed({3'b0, thr_ff});
            mb = ma;
         end
         MS_DOT: begin
            ma = 34'(qn_ff[cmd.uop.idx[1:0]]);
            mb = 34'(kn_ff[cmd.uop.idx[1:0]]);
         end
         MS_LSQ: begin
            ma = 34'(qn_ff[cmd.uop.idx[1:0]]);
            mb = ma;
         end
         MS_KSQ: begin
            ma = 34'(kn_ff[cmd.uop.idx[1:0]]);
            mb = ma;
         end
         MS_PAIR: begin
            unique case (cmd.uop.idx)
               3'd0: begin ma = 34'(qn_ff[0]); mb = 34'(qn_ff[1]); end
               3'd1: begin ma = 34'(qn_ff[3]); mb = 34'(qn_ff[2]); end
               3'd2: begin ma = 34'(qn_ff[0]); mb = 34'(qn_ff[2]); end
               3'd3: begin ma = 34'(qn_ff[3]); mb = 34'(qn_ff[1]); end
               3'd4: begin ma = 34'(qn_ff[1]); mb = 34'(qn_ff[2]); end
               3'd5: begin ma = 34'(qn_ff[3]); mb = 34'(qn_ff[0]); end
               default: ;
            endcase
         end
         MS_DD: begin
            ma = $signed({1'b0, dot_abs[32:0]});
            mb = ma;
         end
         MS_CC: begin
            ma = $signed({19'b0, cos_ff});
            mb = ma;
         end
         MS_NN: begin
            ma = $signed({1'b0, na_ff});
            mb = $signed({1'b0, nb_ff});
         end
         MS_HIC: begin
            ma = $signed({2'b0, phi_ff});
            mb = $signed({4'b0, csq_ff});
         end
         MS_LOC: begin
            ma = $signed({1'b0, plo_ff});
            mb = $signed({4'b0, csq_ff});
         end
         default: ;
      endcase
   end

   // numerators of the rotation matrix
   always_comb begin
      sx  = $signed({4'b0, sq_ff[0]});
      sy  = $signed({4'b0, sq_ff[1]});
      sz  = $signed({4'b0, sq_ff[2]});
      sw  = $signed({4'b0, sq_ff[3]});
      pxy = 35'(pr_ff[0]);
      pwz = 35'(pr_ff[1]);
      pxz = 35'(pr_ff[2]);
      pwy = 35'(pr_ff[3]);
      pyz = 35'(pr_ff[4]);
      pwx = 35'(pr_ff[5]);
      unique case (cmd.ent)
         4'd0: num = sw + sx - sy - sz;
         4'd1: num = (pxy - pwz) <<< 1;
         4'd2: num = (pxz + pwy) <<< 1;
         4'd3: num = (pxy + pwz) <<< 1;
         4'd4: num = sw - sx + sy - sz;
         4'd5: num = (pyz - pwx) <<< 1;
         4'd6: num = (pxz - pwy) <<< 1;
         4'd7: num = (pyz + pwx) <<< 1;
         4'd8: num = sw - sx - sy + sz;
         default: num = '0;
      endcase
      num_abs = (num < 0) ? -num : num;
      qe = $signed({1'b0, qt_ff});
   end

   // transform lanes, one per output row
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         unique case (cmd.xcol)
            2'd0: xrot[r] = rot_ff[r*3];
            2'd1: xrot[r] = rot_ff[r*3 + 1];
            2'd2: xrot[r] = rot_ff[r*3 + 2];
            default: xrot[r] = '0;
         endcase
         xsum[r] = 37'($signed(xacc_ff[r][51:ROT_FRAC])) + 37'(fp_pos_ff[r]);
      end
      unique case (cmd.xcol)
         2'd0: xpt = pt_ff[0];
         2'd1: xpt = pt_ff[1];
         2'd2: xpt = pt_ff[2];
         default: xpt = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= ma * mb;
      for (int r = 0; r < 3; r++) begin
         xprod_ff[r] <= xrot[r] * xpt;
      end

      if (cmd.capture) begin
         for (int i = 0; i < 3; i++) pt_ff[i] <= in_coord[i];
         pt_int_ff  <= req_tdata[175:160];
         pt_ok_ff   <= req_tuser[1];
         pt_last_ff <= req_tlast;
      end

      if (cmd.latch) begin
         for (int i = 0; i < 3; i++) begin
            fp_pos_ff[i] <= lpos_ff[i];
            mag_ff[i] <= (lpos_ff[i] >= kpos_ff[i]) ?
               33'(34'(lpos_ff[i]) - 34'(kpos_ff[i])) :
               33'(34'(kpos_ff[i]) - 34'(lpos_ff[i]));
         end
         for (int i = 0; i < 4; i++) begin
            fp_q_ff[i] <= lq_ff[i];
            qn_ff[i] <= lq_zero ? ((i == 3) ? QUAT_ONE : 16'sd0) : lq_ff[i];
            kn_ff[i] <= kq_zero ? ((i == 3) ? QUAT_ONE : 16'sd0) : kq_ff[i];
         end
      end

      unique case (pend_ff.aop)
         AO_NONE: ;
         AO_TSUM: tsum_ff <= (pend_ff.idx == 3'd0) ? prod_ff[63:0] :
                             tsum_ff + prod_ff[63:0];
         AO_TTHR: tthr_ff <= prod_ff[61:0];
         AO_DOT:  dot_ff <= (pend_ff.idx == 3'd0) ? prod_ff[34:0] :
                            dot_ff + prod_ff[34:0];
         AO_LSQ: begin
            sq_ff[pend_ff.idx[1:0]] <= prod_ff[30:0];
            na_ff <= (pend_ff.idx == 3'd0) ? {2'b0, prod_ff[30:0]} :
                     na_ff + {2'b0, prod_ff[30:0]};
         end
         AO_KSQ:  nb_ff <= (pend_ff.idx == 3'd0) ? {2'b0, prod_ff[30:0]} :
                           nb_ff + {2'b0, prod_ff[30:0]};
         AO_PAIR: pr_ff[pend_ff.idx] <= prod_ff[31:0];
         AO_DD:   dd_ff <= prod_ff[64:0];
         AO_CC:   csq_ff <= prod_ff[29:0];
         AO_NN: begin
            phi_ff <= prod_ff[64:33];
            plo_ff <= prod_ff[32:0];
         end
         AO_HIC:  rhs_ff <= {1'b0, prod_ff[61:0], 33'b0};
         AO_LOC:  rhs_ff <= rhs_ff + {33'b0, prod_ff[62:0]};
         default: ;
      endcase

      if (cmd.div_load) begin
         neg_ff <= (num < 0);
         rem_ff <= {1'b0, num_abs[32:0], 16'b0} + {18'b0, na_ff[32:1]};
         dsr_ff <= {1'b0, na_ff, 16'b0};
         qt_ff  <= '0;
      end
      if (cmd.div_step) begin
         if (rem_ff >= dsr_ff) begin
            rem_ff <= rem_ff - dsr_ff;
            qt_ff  <= {qt_ff[15:0], 1'b1};
         end else begin
            qt_ff  <= {qt_ff[15:0], 1'b0};
         end
         dsr_ff <= dsr_ff >> 1;
      end
      if (cmd.div_store) begin
         rot_ff[cmd.ent] <= neg_ff ? -qe : qe;
      end

      for (int r = 0; r < 3; r++) begin
         unique case (cmd.xacc)
            XA_NONE: ;
            XA_SET:  xacc_ff[r] <= 52'(xprod_ff[r]) + 52'sd32768;
            XA_ADD:  xacc_ff[r] <= xacc_ff[r] + 52'(xprod_ff[r]);
            default: ;
         endcase
         if (cmd.xfin) begin
            if (xsum[r] > 37'sd2147483647) begin
               xres_ff[r] <= 32'sh7FFFFFFF;
            end else if (xsum[r] < -37'sd2147483648) begin
               xres_ff[r] <= 32'sh80000000;
            end else begin
               xres_ff[r] <= xsum[r][31:0];
            end
         end
      end

      if (cmd.out_load) begin
         for (int r = 0; r < 3; r++) begin
            out_map_ff[r] <= cmd.out_point ? xres_ff[r] : 32'sd0;
         end
         out_int_ff     <= cmd.out_point ? pt_int_ff : 16'd0;
         out_present_ff <= cmd.out_point;
         out_end_ff     <= cmd.out_end;
         out_kf_ff      <= cmd.out_kf;
      end
   end

   always_comb begin
      status.in_mode    = mode_type'(req_tuser[0]);
      status.pt_ok      = pt_ok_ff;
      status.pt_last    = pt_last_ff;
      status.trans_pass = (mag_ff[0] >= {2'b0, thr_ff}) ||
                          (mag_ff[1] >= {2'b0, thr_ff}) ||
                          (mag_ff[2] >= {2'b0, thr_ff}) ||
                          (tsum_ff >= {2'b0, tthr_ff});
      status.rot_pass   = ({3'b0, dd_ff, 28'b0} <= rhs_ff);
   end

   assign rsp_tdata = {out_int_ff, out_map_ff[2], out_map_ff[1], out_map_ff[0]};
   assign rsp_tuser = {out_kf_ff, out_present_ff};
   assign rsp_tlast = out_end_ff;

endmodule
`default_nettype wire

FILE: rtl/keyframe_gated_cloud_transform.sv
`default_nettype none
// channel  direction  ports                       contents
// req      in         req_tvalid/tready/tdata     tdata: coord_x, coord_y, coord_z, quat_x,
//                     tuser/tlast                 quat_y, quat_z, quat_w, point_intensity;
//                                                 tuser: mode, point_ok; tlast: frame_last
// rsp      out        rsp_tvalid/tready/tdata     tdata: map_x, map_y, map_z, out_intensity;
//                     tuser/tlast                 tuser: point_present, keyframe_taken;
//                                                 tlast: frame_end
// csr      in         csr_we/index/wdata          0: distance limit, 1: cos_half
//
// a pose beat is taken in the idle state; a point beat runs through the three transform lanes
// (accept, decode, three column multiplies, last add, round and saturate, result load)
// the first point of a frame first runs setup: 28 steps of the shared multiplier
// and nine 17-step restoring divisions for the rotation matrix
// a dropped point that is not frame_last goes back to idle; results sit in an output register,
// so the block only waits when a new result is ready while the previous one is still not taken
// reset is synchronous; it clears control state and restores the register defaults
module keyframe_gated_cloud_transform (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [kgct_pkg::REQ_DATA_W-1:0]   req_tdata,  // coord_x..z, quat_x..w, intensity
   input  wire logic [kgct_pkg::REQ_USER_W-1:0]   req_tuser,  // mode, point_ok
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [kgct_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // map_x..z, out_intensity
   output logic [kgct_pkg::RSP_USER_W-1:0]        rsp_tuser,  // point_present, keyframe_taken
   output logic                                   rsp_tlast,
   input  wire logic                              csr_we,
   input  wire logic [kgct_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [kgct_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import kgct_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   kgct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kgct_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
`default_nettype wire
